// ----- design/mrfb_pkg.sv -----
// Package for the Modbus RTU request frame builder.
// Holds the frame constants, the pipeline payload type and the CRC-16 byte update.
// No dependencies.
`default_nettype none

package mrfb_pkg;

    localparam int unsigned FRAME_LEN   = 8;
    localparam int unsigned PAYLOAD_LEN = 6;

    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  FUNC_WRITE_COIL  = 8'h05;
    localparam logic [7:0]  COIL_ON_HI       = 8'hFF;
    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;

    typedef enum logic {
        OP_WRITE_COIL = 1'b0,
        OP_READ       = 1'b1
    } mrfb_op_t;

    typedef struct packed {
        logic [PAYLOAD_LEN-1:0][7:0] bytes;
        logic [15:0]                 crc;
    } mrfb_frame_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/mrfb_if.sv -----
// Handshake interfaces for the request channel and the frame byte channel.
// Depends on nothing.
`default_nettype none

interface mrfb_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] coil_address;
    logic        coil_on;
    logic [7:0]  function_code;
    logic [15:0] quantity;

    modport source (output valid, output op, output coil_address, output coil_on,
                    output function_code, output quantity, input ready);
    modport sink   (input valid, input op, input coil_address, input coil_on,
                    input function_code, input quantity, output ready);
endinterface

interface mrfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- design/mrfb_frame_asm.sv -----
// First pipeline stage: turns one request word into the six payload bytes.
// Depends on mrfb_pkg and mrfb_if.
`default_nettype none

module mrfb_frame_asm
    import mrfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  slave_address,
    mrfb_req_if.sink         req,
    output mrfb_frame_t      out_frame,
    output logic             out_valid,
    input  wire logic        out_ready
);

    logic        valid_reg;
    mrfb_frame_t frame_reg;
    mrfb_frame_t frame_next;
    logic        advance;

    assign req.ready = !valid_reg || out_ready;
    assign advance   = req.valid && req.ready;

    always_comb
    begin
        frame_next.crc      = CRC_INIT;
        frame_next.bytes[0] = slave_address;
        if (req.op == OP_READ)
        begin
            frame_next.bytes[1] = req.function_code;
            frame_next.bytes[2] = 8'h00;
            frame_next.bytes[3] = 8'h00;
            frame_next.bytes[4] = req.quantity[15:8];
            frame_next.bytes[5] = req.quantity[7:0];
        end
        else
        begin
            frame_next.bytes[1] = FUNC_WRITE_COIL;
            frame_next.bytes[2] = req.coil_address[15:8];
            frame_next.bytes[3] = req.coil_address[7:0];
            frame_next.bytes[4] = req.coil_on ? COIL_ON_HI : 8'h00;
            frame_next.bytes[5] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            frame_reg <= frame_next;
        end
    end

    assign out_frame = frame_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ----- design/mrfb_crc_stage.sv -----
// One CRC pipeline stage: folds two payload bytes into the running CRC-16.
// Depends on mrfb_pkg.
`default_nettype none

module mrfb_crc_stage
    import mrfb_pkg::*;
#(
    parameter int unsigned FIRST_BYTE = 0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mrfb_frame_t in_frame,
    input  wire logic        in_valid,
    output logic             in_ready,
    output mrfb_frame_t      out_frame,
    output logic             out_valid,
    input  wire logic        out_ready
);

    logic        valid_reg;
    mrfb_frame_t frame_reg;
    mrfb_frame_t frame_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        frame_next       = in_frame;
        frame_next.crc   = crc16_byte(crc16_byte(in_frame.crc, in_frame.bytes[FIRST_BYTE]),
                                      in_frame.bytes[FIRST_BYTE + 1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            frame_reg <= frame_next;
        end
    end

    assign out_frame = frame_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ----- design/mrfb_serializer.sv -----
// Last stage: holds one finished frame and sends it one byte per word.
// Depends on mrfb_pkg and mrfb_if.
`default_nettype none

module mrfb_serializer
    import mrfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mrfb_frame_t in_frame,
    input  wire logic        in_valid,
    output logic             in_ready,
    mrfb_byte_if.source      rsp
);

    localparam int unsigned CNT_W = $clog2(FRAME_LEN);

    logic                      busy_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [FRAME_LEN-1:0][7:0] bytes_reg;
    logic                      at_last;
    logic                      load;

    assign at_last  = count_reg == CNT_W'(FRAME_LEN - 1);
    assign in_ready = !busy_reg || (rsp.ready && at_last);
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (busy_reg && rsp.ready)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
            end
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= {in_frame.crc[15:8], in_frame.crc[7:0], in_frame.bytes};
        end
    end

    assign rsp.valid      = busy_reg;
    assign rsp.frame_byte = bytes_reg[count_reg];
    assign rsp.last       = at_last;

endmodule

`default_nettype wire

// ----- design/modbus_request_frame_builder.sv -----
// Modbus RTU request frame builder: one request word in, eight frame byte words out.
// A request is registered in the assembly, three CRC stages and the serializer,
// which shows its first byte. Up to five requests are held in these stages; the
// serializer takes the next frame only as the last byte of its frame is taken.
// Reset clears all valid bits and sets the slave address to 1.
`default_nettype none

module modbus_request_frame_builder
    import mrfb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    mrfb_req_if.sink        req,
    mrfb_byte_if.source     rsp,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    localparam int unsigned CRC_STAGES = PAYLOAD_LEN / 2;

    logic [7:0]  slave_address_reg;
    mrfb_frame_t frame_s [CRC_STAGES+1];
    logic        valid_s [CRC_STAGES+1];
    logic        ready_s [CRC_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            slave_address_reg <= cfg_wdata;
        end
    end

    mrfb_frame_asm u_asm (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (slave_address_reg),
        .req           (req),
        .out_frame     (frame_s[0]),
        .out_valid     (valid_s[0]),
        .out_ready     (ready_s[0])
    );

    for (genvar g = 0; g < CRC_STAGES; g++)
    begin : g_crc
        mrfb_crc_stage #(
            .FIRST_BYTE (2 * g)
        ) u_crc (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_frame  (frame_s[g]),
            .in_valid  (valid_s[g]),
            .in_ready  (ready_s[g]),
            .out_frame (frame_s[g+1]),
            .out_valid (valid_s[g+1]),
            .out_ready (ready_s[g+1])
        );
    end

    mrfb_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_frame (frame_s[CRC_STAGES]),
        .in_valid (valid_s[CRC_STAGES]),
        .in_ready (ready_s[CRC_STAGES]),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// ----- design/mrfb_checker.sv -----
// Port-level checker for the frame builder, attached to the top level by bind.
// Depends on the top level's ports only.
`default_nettype none

module mrfb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [7:0] rsp_frame_byte,
    input wire logic       rsp_last
);

    logic [2:0] byte_cnt_reg;
    logic [3:0] pending_reg;
    logic       in_acc;
    logic       out_acc;
    logic       frame_done;

    assign in_acc     = req_valid && req_ready;
    assign out_acc    = rsp_valid && rsp_ready;
    assign frame_done = out_acc && rsp_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (out_acc)
            begin
                byte_cnt_reg <= byte_cnt_reg + 1'b1;
            end
            pending_reg <= pending_reg + {3'b000, in_acc} - {3'b000, frame_done};
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_last))
        else $error("output word changed while stalled");

    a_last_eighth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_last == (byte_cnt_reg == 3'd7)))
        else $error("last marker not on the eighth byte");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 4'd0)
        else $error("frame byte without an accepted request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd5)
        else $error("more requests in flight than pipeline stages");

endmodule

bind modbus_request_frame_builder mrfb_checker u_mrfb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_frame_byte (rsp.frame_byte),
    .rsp_last       (rsp.last)
);

`default_nettype wire

// ----- sim/modbus_request_frame_builder_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the Modbus RTU request frame builder: drives request words, predicts each
// 8-byte frame with its CRC-16 and checks every frame byte word in order.
// Depends on mrfb_pkg, the interfaces of mrfb_if.sv and the frame builder RTL.
module modbus_request_frame_builder_tb;
    import mrfb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 60;
    localparam int IDLE_PAUSE  = 8;

    typedef struct {
        mrfb_op_t    op;
        logic [15:0] coil_address;
        logic        coil_on;
        logic [7:0]  function_code;
        logic [15:0] quantity;
    } request_t;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last;
    } frame_word_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    mrfb_req_if  req_bus ();
    mrfb_byte_if byte_bus ();

    modbus_request_frame_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (byte_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    request_t    pending_reqs [$];
    frame_word_t expected_bytes [$];
    logic [7:0]  slave_addr_model;
    int          n_queued;
    int          n_taken;
    int          errors;
    int          stall_cycles;
    int          req_wait;
    int          rsp_wait;
    bit          req_taken;
    bit          byte_taken;
    bit          req_burst;
    bit          rsp_burst;

    function automatic int pick_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [15:0] pick_word16();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            return 16'hFFFF;
        end
        else if (sel == 1)
        begin
            return 16'h0000;
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] crc16_modbus(input logic [7:0] msg [PAYLOAD_LEN]);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < PAYLOAD_LEN; i++)
        begin
            crc = crc ^ {8'h00, msg[i]};
            for (int b = 0; b < 8; b++)
            begin
                if (crc[0])
                begin
                    crc = {1'b0, crc[15:1]} ^ CRC_POLY;
                end
                else
                begin
                    crc = {1'b0, crc[15:1]};
                end
            end
        end
        return crc;
    endfunction

    task automatic predict_frame(input request_t r);
        logic [7:0]  msg [PAYLOAD_LEN];
        logic [15:0] crc;
        frame_word_t w;
        msg[0] = slave_addr_model;
        if (r.op == OP_WRITE_COIL)
        begin
            msg[1] = FUNC_WRITE_COIL;
            msg[2] = r.coil_address[15:8];
            msg[3] = r.coil_address[7:0];
            msg[4] = r.coil_on ? COIL_ON_HI : 8'h00;
            msg[5] = 8'h00;
        end
        else
        begin
            msg[1] = r.function_code;
            msg[2] = 8'h00;
            msg[3] = 8'h00;
            msg[4] = r.quantity[15:8];
            msg[5] = r.quantity[7:0];
        end
        crc = crc16_modbus(msg);
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (i < PAYLOAD_LEN)
            begin
                w.frame_byte = msg[i];
            end
            else if (i == PAYLOAD_LEN)
            begin
                w.frame_byte = crc[7:0];
            end
            else
            begin
                w.frame_byte = crc[15:8];
            end
            w.last = (i == FRAME_LEN - 1);
            expected_bytes.push_back(w);
        end
    endtask

    task automatic queue_request(input mrfb_op_t op, input logic [15:0] addr, input logic on,
                                 input logic [7:0] func, input logic [15:0] qty);
        request_t r;
        r.op            = op;
        r.coil_address  = addr;
        r.coil_on       = on;
        r.function_code = func;
        r.quantity      = qty;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (n_taken != n_queued || expected_bytes.size() != 0);
        repeat (IDLE_PAUSE) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(negedge clk)
    begin
        request_t nxt;
        if (rst_n)
        begin
            if (!req_bus.valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && req_wait > 0)
                begin
                    req_bus.valid <= 1'b0;
                    req_wait = req_wait - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    nxt = pending_reqs.pop_front();
                    req_bus.valid         <= 1'b1;
                    req_bus.op            <= nxt.op;
                    req_bus.coil_address  <= nxt.coil_address;
                    req_bus.coil_on       <= nxt.coil_on;
                    req_bus.function_code <= nxt.function_code;
                    req_bus.quantity      <= nxt.quantity;
                    if ($urandom_range(0, 15) == 0)
                    begin
                        req_burst = !req_burst;
                    end
                    req_wait = pick_wait(req_burst);
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_taken)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    rsp_burst = !rsp_burst;
                end
                rsp_wait = pick_wait(rsp_burst);
            end
            if (rsp_wait > 0)
            begin
                byte_bus.ready <= 1'b0;
                rsp_wait = rsp_wait - 1;
            end
            else
            begin
                byte_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t exp_w;
        request_t    got_req;
        if (!rst_n)
        begin
            req_taken        <= 1'b0;
            byte_taken       <= 1'b0;
            slave_addr_model <= SLAVE_ADDR_RESET;
        end
        else
        begin
            req_taken  <= req_bus.valid && req_bus.ready;
            byte_taken <= byte_bus.valid && byte_bus.ready;
            if (cfg_we)
            begin
                slave_addr_model <= cfg_wdata;
            end
            if (byte_bus.valid && byte_bus.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                    begin
                        $display("unexpected frame byte word %02h last %b",
                                 byte_bus.frame_byte, byte_bus.last);
                    end
                    errors++;
                end
                else
                begin
                    exp_w = expected_bytes.pop_front();
                    if (exp_w.frame_byte !== byte_bus.frame_byte
                        || exp_w.last !== byte_bus.last)
                    begin
                        if (errors < MAX_REPORTS)
                        begin
                            $display("frame byte mismatch: expected %02h last %b, got %02h last %b",
                                     exp_w.frame_byte, exp_w.last,
                                     byte_bus.frame_byte, byte_bus.last);
                        end
                        errors++;
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                got_req.op            = mrfb_op_t'(req_bus.op);
                got_req.coil_address  = req_bus.coil_address;
                got_req.coil_on       = req_bus.coil_on;
                got_req.function_code = req_bus.function_code;
                got_req.quantity      = req_bus.quantity;
                predict_frame(got_req);
                n_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (byte_bus.valid && byte_bus.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [7:0] phase_addr [6];
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 8'h00;
        req_bus.valid         = 1'b0;
        req_bus.op            = 1'b0;
        req_bus.coil_address  = 16'h0000;
        req_bus.coil_on       = 1'b0;
        req_bus.function_code = 8'h00;
        req_bus.quantity      = 16'h0000;
        byte_bus.ready        = 1'b0;
        n_queued              = 0;
        n_taken               = 0;
        errors                = 0;
        stall_cycles          = 0;
        req_wait              = 0;
        rsp_wait              = 0;
        req_burst             = 1'b0;
        rsp_burst             = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first phase runs with the slave address left at its reset value.
        queue_request(OP_WRITE_COIL, 16'h0000, 1'b0, 8'h00, 16'h0000);
        queue_request(OP_WRITE_COIL, 16'hFFFF, 1'b1, 8'h00, 16'h0000);
        queue_request(OP_WRITE_COIL, 16'h1234, 1'b1, 8'h03, 16'h0001);
        queue_request(OP_WRITE_COIL, 16'h8000, 1'b0, 8'hFF, 16'hFFFF);
        queue_request(OP_WRITE_COIL, 16'h00FF, 1'b1, 8'hFF, 16'hFFFF);
        queue_request(OP_WRITE_COIL, 16'hFF00, 1'b0, 8'h5A, 16'hA5A5);
        queue_request(OP_WRITE_COIL, 16'h0001, 1'b1, 8'h01, 16'h8000);
        queue_request(OP_READ, 16'h0000, 1'b0, 8'h03, 16'h0001);
        queue_request(OP_READ, 16'h0000, 1'b0, 8'h00, 16'h0000);
        queue_request(OP_READ, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF);
        queue_request(OP_READ, 16'h0000, 1'b0, 8'h01, 16'h8000);
        queue_request(OP_READ, 16'h0000, 1'b0, 8'h02, 16'h00FF);
        queue_request(OP_READ, 16'h0000, 1'b0, 8'h04, 16'hFF00);
        queue_request(OP_READ, 16'hFFFF, 1'b1, 8'h06, 16'h1234);
        queue_request(OP_READ, 16'hABCD, 1'b1, 8'h0F, 16'h007B);
        queue_request(OP_READ, 16'h0000, 1'b0, 8'h10, 16'h0002);
        queue_request(OP_READ, 16'h5555, 1'b0, 8'h80, 16'h5555);
        queue_request(OP_WRITE_COIL, 16'hAAAA, 1'b1, 8'h55, 16'hAAAA);
        queue_request(OP_READ, 16'h0000, 1'b0, 8'h7F, 16'h0001);
        wait_idle();

        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom);
        phase_addr[3] = 8'h01;
        phase_addr[4] = 8'($urandom);
        phase_addr[5] = 8'($urandom);
        for (int p = 0; p < 6; p++)
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= phase_addr[p];
            @(negedge clk);
            cfg_we    <= 1'b0;
            @(posedge clk);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                queue_request(mrfb_op_t'($urandom_range(0, 1)), pick_word16(),
                              1'($urandom), 8'($urandom), pick_word16());
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $display("%0d frame byte words never arrived", expected_bytes.size());
            errors += expected_bytes.size();
        end
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
